/* rtl/pld_pkg.sv */
// ---------------------------------------------------------------------------
// pld_pkg
// Shared types and constants of the polynomial long division unit.
// ---------------------------------------------------------------------------
package pld_pkg;

  localparam int MAX_DEGREE_DEF = 31;

  localparam logic [1:0] FUNC_DIVIDEND = 2'd0;
  localparam logic [1:0] FUNC_DIVISOR  = 2'd1;
  localparam logic [1:0] FUNC_DIVIDE   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;

  localparam logic PART_QUOTIENT  = 1'b0;
  localparam logic PART_REMAINDER = 1'b1;

  // 0.1 - 1e-8 in Q31.32, rounded up
  localparam logic signed [63:0] KEEP_LIMIT = 64'sd429496687;
  localparam logic signed [63:0] Q_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         exponent;
    logic signed [15:0] coefficient;
  } request_t;

  typedef struct packed {
    logic               part;
    logic [5:0]         term_count;
    logic [4:0]         term_exponent;
    logic signed [63:0] term_value;
    logic               divide_error;
    logic               last;
  } result_t;

  function automatic logic significant(input logic signed [63:0] v);
    significant = (v >= KEEP_LIMIT) || (v <= -KEEP_LIMIT);
  endfunction

endpackage

/* rtl/pld_ram.sv */
// ---------------------------------------------------------------------------
// pld_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pld_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/polynomial_long_division.sv */
// ---------------------------------------------------------------------------
// polynomial_long_division
// Loads dividend and divisor terms, then runs saturating Q31.32 long
// division over RAM-held coefficients and emits quotient and remainder terms.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------
//  request  | start & !busy             | request (func, exponent, coeff)
//  result   | result_valid, one cycle   | result (part, count, exp, value,
//           |                           |   divide_error, last)
//
// Load requests are accepted back to back. A divide request holds busy
// while the sequencer walks the RAMs: per quotient row a dividend read, a
// divider seed, the bit-serial divider and a significance check, then, for a
// significant quotient term, per divisor term a read, multiply, saturate and
// subtract/write back. Emission scans the quotient slots and emits each
// quotient term, then reads each remainder entry in a count pass and again
// in an emit pass.
// Reset clears the valid masks and degrees at once; no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
module polynomial_long_division
  import pld_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     result_valid,
  output result_t  result
);

  localparam int NTERMS = MAX_DEGREE + 1;
  localparam int AW = $clog2(NTERMS);
  localparam int CW = $clog2(NTERMS + 1);
  localparam logic [AW-1:0] TOP_IDX = AW'(MAX_DEGREE);

  typedef enum logic [18:0] {
    S_IDLE    = 19'd1 << 0,
    S_LEAD    = 19'd1 << 1,
    S_O_RD    = 19'd1 << 2,
    S_O_LOAD  = 19'd1 << 3,
    S_O_DIV   = 19'd1 << 4,
    S_O_CHK   = 19'd1 << 5,
    S_J_RD    = 19'd1 << 6,
    S_J_MUL   = 19'd1 << 7,
    S_J_SAT   = 19'd1 << 8,
    S_J_WR    = 19'd1 << 9,
    S_Q_START = 19'd1 << 10,
    S_Q_SCAN  = 19'd1 << 11,
    S_Q_OUT   = 19'd1 << 12,
    S_R_START = 19'd1 << 13,
    S_R_CRD   = 19'd1 << 14,
    S_R_CCHK  = 19'd1 << 15,
    S_R_ESTRT = 19'd1 << 16,
    S_R_ERD   = 19'd1 << 17,
    S_R_EOUT  = 19'd1 << 18
  } state_t;

  state_t state, state_next;

  // control registers
  logic [NTERMS-1:0] dvd_vld, dvs_vld, qvalid;
  logic [AW-1:0]     dvd_deg, dvs_deg;
  logic [AW-1:0]     i_idx, j_idx, q_base, idx;
  logic [CW-1:0]     qcnt, rcnt, remit;
  logic [5:0]        div_cnt;
  logic              dvd_rvld, dvs_rvld;

  // datapath registers
  logic signed [15:0] lead;
  logic [15:0]        dmag;
  logic [15:0]        drem;
  logic [63:0]        dnum;
  logic               dneg;
  logic signed [63:0] qv;
  logic signed [63:0] a_op;
  logic [79:0]        prod;
  logic               pneg;
  logic signed [63:0] p_sat;

  // RAM ports
  logic          dvd_we, dvd_re, dvs_we, dvs_re, q_we, q_re;
  logic [AW-1:0] dvd_waddr, dvd_raddr, dvs_raddr, q_raddr;
  logic [63:0]   dvd_wdata, dvd_rdata, q_rdata;
  logic [15:0]   dvs_rdata;

  logic signed [63:0] dvd_rd;
  logic signed [15:0] dvs_rd;
  logic               load_ok, accept;
  logic [AW-1:0]      ld_addr, jaddr;
  logic [16:0]        trial;
  logic               qbit;
  logic signed [63:0] div_res, sub_raw, sub_res;
  logic [63:0]        mv;
  logic [15:0]        mb;
  logic               res_load, fin;
  result_t            res_next;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign load_ok = (request.exponent <= 5'(MAX_DEGREE));
  assign ld_addr = request.exponent[AW-1:0];
  assign jaddr   = q_base + j_idx;
  assign dvd_rd  = dvd_rvld ? $signed(dvd_rdata) : 64'sd0;
  assign dvs_rd  = dvs_rvld ? $signed(dvs_rdata) : 16'sd0;

  pld_ram #(.WIDTH(64), .DEPTH(NTERMS)) u_dvd_ram (
    .clk(clk), .we(dvd_we), .waddr(dvd_waddr), .wdata(dvd_wdata),
    .re(dvd_re), .raddr(dvd_raddr), .rdata(dvd_rdata)
  );

  pld_ram #(.WIDTH(16), .DEPTH(NTERMS)) u_dvs_ram (
    .clk(clk), .we(dvs_we), .waddr(ld_addr), .wdata(request.coefficient),
    .re(dvs_re), .raddr(dvs_raddr), .rdata(dvs_rdata)
  );

  pld_ram #(.WIDTH(64), .DEPTH(NTERMS)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_base), .wdata(qv),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  // One restoring step of the bit-serial divider on magnitudes
  assign trial = {drem, dnum[63]};
  assign qbit  = (trial >= {1'b0, dmag});

  // Finish the division: apply sign, saturate the one overflow case
  always_comb begin
    if (dneg) begin
      div_res = $signed(-dnum);
    end else if (dnum[63]) begin
      div_res = Q_MAX;
    end else begin
      div_res = $signed(dnum);
    end
  end

  // Magnitudes for the multiplier
  assign mv = qv[63] ? 64'(-qv) : 64'(qv);
  assign mb = dvs_rd[15] ? 16'(-dvs_rd) : 16'(dvs_rd);

  // Saturating subtract of the product from the dividend term
  always_comb begin
    sub_raw = a_op - p_sat;
    if ((a_op[63] != p_sat[63]) && (sub_raw[63] != a_op[63])) begin
      sub_res = a_op[63] ? Q_MIN : Q_MAX;
    end else begin
      sub_res = sub_raw;
    end
  end

  // Sequencer: RAM access control, result formation, next state
  always_comb begin
    state_next = state;
    dvd_we    = 1'b0;
    dvd_waddr = ld_addr;
    dvd_wdata = {{16{request.coefficient[15]}}, request.coefficient, 32'd0};
    dvd_re    = 1'b0;
    dvd_raddr = i_idx;
    dvs_we    = 1'b0;
    dvs_re    = 1'b0;
    dvs_raddr = dvs_deg;
    q_we      = 1'b0;
    q_re      = 1'b0;
    q_raddr   = idx;
    res_load  = 1'b0;
    res_next  = '0;
    fin       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.func)
            FUNC_DIVIDEND: dvd_we = load_ok;
            FUNC_DIVISOR:  dvs_we = load_ok;
            FUNC_DIVIDE: begin
              dvs_re     = 1'b1;
              state_next = S_LEAD;
            end
            default: ;
          endcase
        end
      end
      S_LEAD: begin
        if (dvs_rd == 16'sd0) begin
          res_load              = 1'b1;
          res_next.divide_error = 1'b1;
          res_next.last         = 1'b1;
          fin                   = 1'b1;
          state_next            = S_IDLE;
        end else if (dvd_deg < dvs_deg) begin
          state_next = S_Q_START;
        end else begin
          state_next = S_O_RD;
        end
      end
      S_O_RD: begin
        dvd_re     = 1'b1;
        state_next = S_O_LOAD;
      end
      S_O_LOAD: state_next = S_O_DIV;
      S_O_DIV: begin
        if (div_cnt == 6'd0) begin
          state_next = S_O_CHK;
        end
      end
      S_O_CHK: begin
        if (significant(div_res)) begin
          state_next = S_J_RD;
        end else if (i_idx == dvs_deg) begin
          state_next = S_Q_START;
        end else begin
          state_next = S_O_RD;
        end
      end
      S_J_RD: begin
        dvd_re     = 1'b1;
        dvd_raddr  = jaddr;
        dvs_re     = 1'b1;
        dvs_raddr  = j_idx;
        state_next = S_J_MUL;
      end
      S_J_MUL: state_next = S_J_SAT;
      S_J_SAT: state_next = S_J_WR;
      S_J_WR: begin
        dvd_we    = 1'b1;
        dvd_waddr = jaddr;
        dvd_wdata = sub_res;
        if (j_idx != '0) begin
          state_next = S_J_RD;
        end else if (i_idx == dvs_deg) begin
          state_next = S_Q_START;
        end else begin
          state_next = S_O_RD;
        end
      end
      S_Q_START: begin
        if (qcnt == '0) begin
          res_load   = 1'b1;
          res_next.part = PART_QUOTIENT;
          state_next = S_R_START;
        end else begin
          state_next = S_Q_SCAN;
        end
      end
      S_Q_SCAN: begin
        if (qvalid[idx]) begin
          q_re       = 1'b1;
          state_next = S_Q_OUT;
        end else if (idx == '0) begin
          state_next = S_R_START;
        end
      end
      S_Q_OUT: begin
        res_load               = 1'b1;
        res_next.part          = PART_QUOTIENT;
        res_next.term_count    = 6'(qcnt);
        res_next.term_exponent = 5'(idx);
        res_next.term_value    = $signed(q_rdata);
        state_next             = (idx == '0) ? S_R_START : S_Q_SCAN;
      end
      S_R_START: state_next = (dvs_deg == '0) ? S_R_ESTRT : S_R_CRD;
      S_R_CRD: begin
        dvd_re     = 1'b1;
        dvd_raddr  = idx;
        state_next = S_R_CCHK;
      end
      S_R_CCHK: state_next = (idx == '0) ? S_R_ESTRT : S_R_CRD;
      S_R_ESTRT: begin
        if (rcnt == '0) begin
          res_load      = 1'b1;
          res_next.part = PART_REMAINDER;
          res_next.last = 1'b1;
          fin           = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = S_R_ERD;
        end
      end
      S_R_ERD: begin
        dvd_re     = 1'b1;
        dvd_raddr  = idx;
        state_next = S_R_EOUT;
      end
      S_R_EOUT: begin
        state_next = S_R_ERD;
        if (significant(dvd_rd)) begin
          res_load               = 1'b1;
          res_next.part          = PART_REMAINDER;
          res_next.term_count    = 6'(rcnt);
          res_next.term_exponent = 5'(idx);
          res_next.term_value    = dvd_rd;
          if (remit == rcnt - CW'(1)) begin
            res_next.last = 1'b1;
            fin           = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    // Quotient term is stored at the start of its subtraction pass
    if (state == S_O_CHK) begin
      q_we = 1'b0;
    end
    if (state == S_J_RD && j_idx == dvs_deg) begin
      q_we = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dvd_vld      <= '0;
      dvs_vld      <= '0;
      qvalid       <= '0;
      dvd_deg      <= '0;
      dvs_deg      <= '0;
      qcnt         <= '0;
      rcnt         <= '0;
      remit        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_load;
      if (dvd_we) begin
        dvd_vld[dvd_waddr] <= 1'b1;
      end
      if (state == S_IDLE && dvd_we && ld_addr > dvd_deg) begin
        dvd_deg <= ld_addr;
      end
      if (dvs_we) begin
        dvs_vld[ld_addr] <= 1'b1;
        if (ld_addr > dvs_deg) begin
          dvs_deg <= ld_addr;
        end
      end
      if (state == S_O_CHK && significant(div_res)) begin
        qvalid[i_idx - dvs_deg] <= 1'b1;
        qcnt                    <= qcnt + CW'(1);
      end
      if (state == S_R_START) begin
        rcnt <= '0;
      end
      if (state == S_R_CCHK && significant(dvd_rd)) begin
        rcnt <= rcnt + CW'(1);
      end
      if (state == S_R_ESTRT) begin
        remit <= '0;
      end
      if (state == S_R_EOUT && significant(dvd_rd)) begin
        remit <= remit + CW'(1);
      end
      // drop all stored terms once the run is reported
      if (fin) begin
        dvd_vld <= '0;
        dvs_vld <= '0;
        qvalid  <= '0;
        dvd_deg <= '0;
        dvs_deg <= '0;
        qcnt    <= '0;
      end
    end
  end

  // Indices, divider and arithmetic pipeline
  always_ff @(posedge clk) begin
    if (dvd_re) begin
      dvd_rvld <= dvd_vld[dvd_raddr];
    end
    if (dvs_re) begin
      dvs_rvld <= dvs_vld[dvs_raddr];
    end
    if (res_load) begin
      result <= res_next;
    end
    unique case (state)
      S_LEAD: begin
        lead  <= dvs_rd;
        dmag  <= dvs_rd[15] ? 16'(-dvs_rd) : 16'(dvs_rd);
        i_idx <= dvd_deg;
      end
      S_O_LOAD: begin
        // seed the divider with the magnitude of the current term
        dnum    <= dvd_rd[63] ? 64'(-dvd_rd) : 64'(dvd_rd);
        drem    <= '0;
        dneg    <= dvd_rd[63] != lead[15];
        div_cnt <= 6'd63;
      end
      S_O_DIV: begin
        drem    <= qbit ? 16'(trial - {1'b0, dmag}) : trial[15:0];
        dnum    <= {dnum[62:0], qbit};
        div_cnt <= div_cnt - 6'd1;
      end
      S_O_CHK: begin
        qv     <= div_res;
        q_base <= i_idx - dvs_deg;
        j_idx  <= dvs_deg;
        if (!significant(div_res) && i_idx != dvs_deg) begin
          i_idx <= i_idx - AW'(1);
        end
      end
      S_J_MUL: begin
        a_op <= dvd_rd;
        prod <= mv * mb;
        pneg <= qv[63] != dvs_rd[15];
      end
      S_J_SAT: begin
        if (prod > {16'd0, pneg, {63{!pneg}}}) begin
          p_sat <= pneg ? Q_MIN : Q_MAX;
        end else begin
          p_sat <= pneg ? $signed(-prod[63:0]) : $signed(prod[63:0]);
        end
      end
      S_J_WR: begin
        if (j_idx != '0) begin
          j_idx <= j_idx - AW'(1);
        end else if (i_idx != dvs_deg) begin
          i_idx <= i_idx - AW'(1);
        end
      end
      S_Q_START: idx <= TOP_IDX;
      S_Q_SCAN: begin
        if (!qvalid[idx] && idx != '0) begin
          idx <= idx - AW'(1);
        end
      end
      S_Q_OUT: begin
        if (idx != '0) begin
          idx <= idx - AW'(1);
        end
      end
      S_R_START: idx <= dvs_deg - AW'(1);
      S_R_CCHK: begin
        if (idx != '0) begin
          idx <= idx - AW'(1);
        end
      end
      S_R_ESTRT: idx <= dvs_deg - AW'(1);
      S_R_EOUT: begin
        if (idx != '0) begin
          idx <= idx - AW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule
